>>> src/sliding_window_min_max_top_defines.svh
// Assertion macros shared by the sliding window min/max block.
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_DEFINES_SVH

// Same-cycle implication, checked on the block clock outside reset.
`define SWMM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swmm: same-cycle check failed");

// Next-cycle implication, checked on the block clock outside reset.
`define SWMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swmm: next-cycle check failed");

`endif

>>> src/swmm_pkg.sv
`timescale 1ns / 1ps

package swmm_pkg;

    // Sizing
    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_W   = 32;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int POS_W      = CNT_W;
    localparam int ENT_W      = POS_W + SAMPLE_W;
    localparam int ADDR_W     = SLOT_W + 1;
    localparam int WIN_REG_W  = 7;

    // Register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;

    // Deque select: upper RAM address bit
    localparam logic DQ_MAX = 1'b0;
    localparam logic DQ_MIN = 1'b1;

    typedef enum logic [1:0] {
        CMP_EVICT,
        CMP_POP_MAX,
        CMP_POP_MIN
    } t_cmp_op;

    typedef struct packed {
        t_cmp_op                    op;
        logic signed [SAMPLE_W-1:0] sample;
        logic [POS_W-1:0]           pos;
        logic [CNT_W-1:0]           win;
    } t_cmp_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EV_RD,
        ST_EV_CMP,
        ST_POP_RD,
        ST_POP_CMP,
        ST_PUSH,
        ST_HD_RD,
        ST_HD_MAX,
        ST_HD_MIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                       busy;
        logic                       valid;
        logic signed [SAMPLE_W-1:0] win_min;
        logic signed [SAMPLE_W-1:0] win_max;
    } t_res;

    // Zero acts as one, anything above the deque depth is clamped
    function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_REG_W-1:0] ws);
        logic [CNT_W-1:0] w;
        if (ws == '0) begin
            w = CNT_W'(1);
        end else if (int'(ws) > MAX_WINDOW) begin
            w = CNT_W'(MAX_WINDOW);
        end else begin
            w = CNT_W'(ws);
        end
        return w;
    endfunction

endpackage

>>> src/swmm_ram.sv
`timescale 1ns / 1ps

module swmm_ram #(
    parameter int ADDR_BITS = 7,
    parameter int DATA_BITS = 39
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [0:(1 << ADDR_BITS)-1];
    logic [DATA_BITS-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/swmm_cmp.sv
`timescale 1ns / 1ps

module swmm_cmp (
    input  swmm_pkg::t_cmp_req          i_req,
    input  logic [swmm_pkg::ENT_W-1:0]  i_entry,
    output logic                        o_drop
);

    logic signed [swmm_pkg::SAMPLE_W-1:0] w_val;
    logic [swmm_pkg::POS_W-1:0]           w_pos;
    logic [swmm_pkg::POS_W-1:0]           w_age;

    assign w_val = i_entry[swmm_pkg::SAMPLE_W-1:0];
    assign w_pos = i_entry[swmm_pkg::ENT_W-1:swmm_pkg::SAMPLE_W];
    // position wraps, so age is a modular difference
    assign w_age = i_req.pos - w_pos;

    // Shared compare: head age check or tail dominance check
    always_comb begin
        unique case (i_req.op)
            swmm_pkg::CMP_EVICT:   o_drop = (w_age >= i_req.win);
            swmm_pkg::CMP_POP_MAX: o_drop = (w_val < i_req.sample);
            swmm_pkg::CMP_POP_MIN: o_drop = (w_val > i_req.sample);
            default:               o_drop = 1'b0;
        endcase
    end

endmodule

>>> src/swmm_ctrl.sv
`timescale 1ns / 1ps

module swmm_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                               i_sos,
    input  logic [swmm_pkg::CNT_W-1:0]         i_win,
    input  logic                               i_clear,
    input  logic                               i_take,
    output swmm_pkg::t_res                     o_res
);

    swmm_pkg::t_state                       r_state, n_state;
    logic                                   r_sel, n_sel;
    logic [swmm_pkg::SLOT_W-1:0]            r_head [0:1];
    logic [swmm_pkg::SLOT_W-1:0]            n_head [0:1];
    logic [swmm_pkg::CNT_W-1:0]             r_cnt  [0:1];
    logic [swmm_pkg::CNT_W-1:0]             n_cnt  [0:1];
    logic [swmm_pkg::POS_W-1:0]             r_pos, n_pos;
    logic [swmm_pkg::CNT_W-1:0]             r_fill, n_fill;
    logic signed [swmm_pkg::SAMPLE_W-1:0]   r_sample, n_sample;
    logic signed [swmm_pkg::SAMPLE_W-1:0]   r_hd_max, n_hd_max;
    logic signed [swmm_pkg::SAMPLE_W-1:0]   r_hd_min, n_hd_min;

    logic [swmm_pkg::SLOT_W-1:0]            w_head_sel;
    logic [swmm_pkg::CNT_W-1:0]             w_cnt_sel;
    logic [swmm_pkg::SLOT_W-1:0]            w_last_slot;
    logic [swmm_pkg::SLOT_W-1:0]            w_free_slot;
    logic [swmm_pkg::CNT_W-1:0]             w_fill_inc;

    logic                                   w_we;
    logic                                   w_re;
    logic [swmm_pkg::ADDR_W-1:0]            w_raddr;
    logic [swmm_pkg::ADDR_W-1:0]            w_waddr;
    logic [swmm_pkg::ENT_W-1:0]             w_wdata;
    logic [swmm_pkg::ENT_W-1:0]             w_rdata;
    swmm_pkg::t_cmp_req                     w_cmp_req;
    logic                                   w_drop;

    // Pointers of the deque being worked on
    assign w_head_sel  = r_head[r_sel];
    assign w_cnt_sel   = r_cnt[r_sel];
    assign w_last_slot = w_head_sel + w_cnt_sel[swmm_pkg::SLOT_W-1:0]
                         - swmm_pkg::SLOT_W'(1);
    assign w_free_slot = w_head_sel + w_cnt_sel[swmm_pkg::SLOT_W-1:0];
    assign w_fill_inc  = (r_fill < swmm_pkg::CNT_W'(swmm_pkg::MAX_WINDOW))
                         ? r_fill + swmm_pkg::CNT_W'(1) : r_fill;

    // Both deques share one RAM: upper address bit picks the deque
    swmm_ram #(
        .ADDR_BITS (swmm_pkg::ADDR_W),
        .DATA_BITS (swmm_pkg::ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    swmm_cmp u_cmp (
        .i_req   (w_cmp_req),
        .i_entry (w_rdata),
        .o_drop  (w_drop)
    );

    // Sequencer: evict heads, pop tails, push, then fetch both heads once a result is due
    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_head   = r_head;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_fill   = r_fill;
        n_sample = r_sample;
        n_hd_max = r_hd_max;
        n_hd_min = r_hd_min;

        w_we    = 1'b0;
        w_re    = 1'b0;
        w_raddr = {r_sel, w_head_sel};
        w_waddr = {r_sel, w_free_slot};
        w_wdata = {r_pos, r_sample};

        w_cmp_req.op     = swmm_pkg::CMP_EVICT;
        w_cmp_req.sample = r_sample;
        w_cmp_req.pos    = r_pos;
        w_cmp_req.win    = i_win;

        unique case (r_state)
            swmm_pkg::ST_IDLE: begin
                if (i_clear || (i_accept && i_sos)) begin
                    n_head[0] = '0;
                    n_head[1] = '0;
                    n_cnt[0]  = '0;
                    n_cnt[1]  = '0;
                    n_pos     = '0;
                    n_fill    = '0;
                end
                if (i_accept) begin
                    n_sample = i_sample;
                    n_sel    = swmm_pkg::DQ_MAX;
                    n_state  = swmm_pkg::ST_EV_RD;
                end
            end
            swmm_pkg::ST_EV_RD: begin
                if (w_cnt_sel == '0) begin
                    n_state = swmm_pkg::ST_POP_RD;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = {r_sel, w_head_sel};
                    n_state = swmm_pkg::ST_EV_CMP;
                end
            end
            swmm_pkg::ST_EV_CMP: begin
                w_cmp_req.op = swmm_pkg::CMP_EVICT;
                if (w_drop) begin
                    n_head[r_sel] = w_head_sel + swmm_pkg::SLOT_W'(1);
                    n_cnt[r_sel]  = w_cnt_sel - swmm_pkg::CNT_W'(1);
                    n_state       = swmm_pkg::ST_EV_RD;
                end else begin
                    n_state = swmm_pkg::ST_POP_RD;
                end
            end
            swmm_pkg::ST_POP_RD: begin
                if (w_cnt_sel == '0) begin
                    n_state = swmm_pkg::ST_PUSH;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = {r_sel, w_last_slot};
                    n_state = swmm_pkg::ST_POP_CMP;
                end
            end
            swmm_pkg::ST_POP_CMP: begin
                w_cmp_req.op = (r_sel == swmm_pkg::DQ_MAX) ? swmm_pkg::CMP_POP_MAX
                                                           : swmm_pkg::CMP_POP_MIN;
                if (w_drop) begin
                    n_cnt[r_sel] = w_cnt_sel - swmm_pkg::CNT_W'(1);
                    n_state      = swmm_pkg::ST_POP_RD;
                end else begin
                    n_state = swmm_pkg::ST_PUSH;
                end
            end
            swmm_pkg::ST_PUSH: begin
                if (w_cnt_sel < swmm_pkg::CNT_W'(swmm_pkg::MAX_WINDOW)) begin
                    w_we         = 1'b1;
                    n_cnt[r_sel] = w_cnt_sel + swmm_pkg::CNT_W'(1);
                end
                if (r_sel == swmm_pkg::DQ_MAX) begin
                    n_sel   = swmm_pkg::DQ_MIN;
                    n_state = swmm_pkg::ST_EV_RD;
                end else begin
                    n_pos  = r_pos + swmm_pkg::POS_W'(1);
                    n_fill = w_fill_inc;
                    if (w_fill_inc >= i_win) begin
                        n_state = swmm_pkg::ST_HD_RD;
                    end else begin
                        n_state = swmm_pkg::ST_IDLE;
                    end
                end
            end
            swmm_pkg::ST_HD_RD: begin
                w_re    = 1'b1;
                w_raddr = {swmm_pkg::DQ_MAX, r_head[0]};
                n_state = swmm_pkg::ST_HD_MAX;
            end
            swmm_pkg::ST_HD_MAX: begin
                n_hd_max = w_rdata[swmm_pkg::SAMPLE_W-1:0];
                w_re     = 1'b1;
                w_raddr  = {swmm_pkg::DQ_MIN, r_head[1]};
                n_state  = swmm_pkg::ST_HD_MIN;
            end
            swmm_pkg::ST_HD_MIN: begin
                n_hd_min = w_rdata[swmm_pkg::SAMPLE_W-1:0];
                n_state  = swmm_pkg::ST_DONE;
            end
            swmm_pkg::ST_DONE: begin
                if (i_take) begin
                    n_state = swmm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swmm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= swmm_pkg::ST_IDLE;
            r_sel     <= swmm_pkg::DQ_MAX;
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
            r_pos     <= '0;
            r_fill    <= '0;
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_head[0] <= n_head[0];
            r_head[1] <= n_head[1];
            r_cnt[0]  <= n_cnt[0];
            r_cnt[1]  <= n_cnt[1];
            r_pos     <= n_pos;
            r_fill    <= n_fill;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_hd_max <= n_hd_max;
        r_hd_min <= n_hd_min;
    end

    assign o_res.busy    = (r_state != swmm_pkg::ST_IDLE);
    assign o_res.valid   = (r_state == swmm_pkg::ST_DONE);
    assign o_res.win_min = r_hd_min;
    assign o_res.win_max = r_hd_max;

endmodule

>>> src/sliding_window_min_max_top.sv
// Sliding window minimum and maximum over a stream of signed samples.
// Input channel: i_in_valid / o_in_stall carry i_sample and i_start_of_stream.
// A request is taken when i_in_valid is high and o_in_stall is low; the block
// raises o_in_stall while it works on a sample. Output channel: o_out_valid /
// i_out_stall carry o_window_min and o_window_max, one result per sample once
// window_size samples of the stream have arrived, none before.
// For each request the max deque and then the min deque evict old heads, pop
// dominated tails and push the sample; once a result is due both heads are
// read. Each dropped entry (old head or dominated tail) adds a RAM read and a
// compare, and each sample is dropped at most once per deque. The next request
// can be taken in the cycle after the result is registered; when no result is
// due the head reads are skipped. The sequencer walks one RAM with one read
// port and the one shared compare unit. The output register lets the next
// request in while a result waits; a stalled receiver holds the result, and
// the block waits for it only when a second result is ready. Register
// window_size (byte address 0) is to be written over the APB port while idle;
// the block does not enforce this. A write while idle, like i_start_of_stream,
// starts a new stream. Reset (synchronous, active low) empties both deques,
// sets window_size to 1 and clears o_out_valid. No clearing pass is needed.
`timescale 1ns / 1ps
`include "sliding_window_min_max_top_defines.svh"

module sliding_window_min_max_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [swmm_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                  i_start_of_stream,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [swmm_pkg::SAMPLE_W-1:0]  o_window_min,
    output logic signed [swmm_pkg::SAMPLE_W-1:0]  o_window_max,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [swmm_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [swmm_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [swmm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    logic [swmm_pkg::WIN_REG_W-1:0]         r_window_size;
    logic                                   r_out_valid;
    logic signed [swmm_pkg::SAMPLE_W-1:0]   r_out_min;
    logic signed [swmm_pkg::SAMPLE_W-1:0]   r_out_max;

    logic                                   w_reg_hit;
    logic                                   w_cfg_wr;
    logic                                   w_in_accept;
    logic                                   w_take;
    swmm_pkg::t_res                         w_res;

    // Register decode
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[swmm_pkg::APB_ADDR_W-1:2] == swmm_pkg::REG_WINDOW_SIZE);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_reg_hit;
    assign prdata    = w_reg_hit ? swmm_pkg::APB_DATA_W'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swmm_pkg::WIN_REG_W'(1);
        end else if (w_cfg_wr) begin
            r_window_size <= pwdata[swmm_pkg::WIN_REG_W-1:0];
        end
    end

    // Sample request and sequencer
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall  = w_res.busy;
    assign w_take      = !r_out_valid || !i_out_stall;

    swmm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_accept),
        .i_sample (i_sample),
        .i_sos    (i_start_of_stream),
        .i_win    (swmm_pkg::eff_window(r_window_size)),
        .i_clear  (w_cfg_wr),
        .i_take   (w_take),
        .o_res    (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_take) begin
            r_out_min <= w_res.win_min;
            r_out_max <= w_res.win_max;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_min = r_out_min;
    assign o_window_max = r_out_max;

    // Checks
    `SWMM_ASSERT_NEXT(a_busy_after_req, w_in_accept, o_in_stall)
    `SWMM_ASSERT_IMP(a_result_only_busy, w_res.valid, w_res.busy)
    `SWMM_ASSERT_IMP(a_out_from_seq, $rose(r_out_valid), $past(w_res.valid))

endmodule
